[rtl/core/chorus_pkg.sv]
// ----------------------------------------------------------------------------
// chorus_pkg
// Shared constants, register codes and lane control type for the stereo chorus.
// ----------------------------------------------------------------------------
package chorus_pkg;

  // sample and store geometry
  localparam int SAMPLE_W      = 16;
  localparam int STORE_AW      = 11;
  localparam int STORE_DEPTH   = 2 ** STORE_AW;
  localparam int DELAY_SAMPLES = 1000;

  // lfo geometry: sine sampled at 2**TBL_LOG2 phase points of a 32-bit phase
  localparam int TBL_LOG2 = 10;
  localparam int PHASE_W  = 32;

  // q1.15 arithmetic
  localparam int FRAC_W  = 15;
  localparam int ONE_Q15 = 32768;
  localparam int SINE_W  = 17;

  // configuration fields
  localparam int GAIN_W  = 16;
  localparam int PSTEP_W = 25;
  localparam int DEPTH_W = 9;
  localparam int CFG_W   = 25;
  localparam int CFG_AW  = 2;

  // offset product width, wide enough to carry the whole part into an address
  localparam int OFS_PROD_W = SINE_W + DEPTH_W + 1;
  localparam int OFS_W      = (FRAC_W + STORE_AW > OFS_PROD_W) ? FRAC_W + STORE_AW
                                                               : OFS_PROD_W;

  // blend accumulator widths
  localparam int ACC_W = SAMPLE_W + GAIN_W + 2;
  localparam int FL_W  = ACC_W - FRAC_W;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef enum logic [CFG_AW-1:0] {
    REG_MIX        = 2'd0,
    REG_FEEDBACK   = 2'd1,
    REG_PHASE_STEP = 2'd2,
    REG_DEPTH      = 2'd3
  } cfg_reg_t;

  // control shared by both channel lanes
  typedef struct packed {
    logic                start;
    logic                clr_en;
    logic [STORE_AW-1:0] clr_addr;
    logic [STORE_AW-1:0] wr_pos;
    logic [GAIN_W-1:0]   mix_g;
    logic [GAIN_W-1:0]   fb_g;
  } lane_ctrl_t;

endpackage

[rtl/core/stereo_chorus_modulated_delay.sv]
// ----------------------------------------------------------------------------
// stereo_chorus_modulated_delay
// Stereo chorus: sine lfo modulates an interpolated delay read per channel,
// two channel lanes run side by side and a merge stage forms the output beat.
// ----------------------------------------------------------------------------
// Sequence: an lfo pass, then four lane steps in both lanes (tap read,
// interpolation, mix, store write), then a merge that a stalled result delays.
// A new input beat is taken only after the merge, so one beat is in flight.
// Reset: rst_n low clears control and loads register defaults; after it a
// clearing pass over all 2048 addresses zeroes both delay stores before in_tready rises.
// ----------------------------------------------------------------------------
module stereo_chorus_modulated_delay
  import chorus_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  // input stream
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [31:0]         in_tdata,   // [15:0] left_in, [31:16] right_in
  input  logic                in_tlast,   // block_last
  // result stream
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [31:0]         out_tdata,  // [15:0] left_out, [31:16] right_out
  output logic                out_tlast,  // block_last_out
  // configuration
  input  logic                cfg_we,
  input  logic [CFG_AW-1:0]   cfg_addr,
  input  logic [CFG_W-1:0]    cfg_wdata
);

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_LFO   = 5'b00100,
    ST_LANE  = 5'b01000,
    ST_MERGE = 5'b10000
  } state_t;

  state_t              state_r;
  state_t              state_nxt;
  logic [STORE_AW-1:0] clr_addr_r;
  logic [STORE_AW-1:0] wp_r;
  logic [GAIN_W-1:0]   mix_gain_r;
  logic [GAIN_W-1:0]   fb_gain_r;
  logic [PSTEP_W-1:0]  phase_step_r;
  logic [DEPTH_W-1:0]  depth_r;
  sample_t             left_in_r;
  sample_t             right_in_r;
  logic                last_r;
  logic                out_tvalid_r;
  logic [31:0]         out_tdata_r;
  logic                out_tlast_r;

  logic                in_acc;
  logic                lfo_done;
  logic                lane_start;
  logic                lane_done_l;
  logic                lane_done_r;
  logic                out_ld;
  logic [STORE_AW-1:0] ofs_int;
  logic [FRAC_W-1:0]   ofs_frac;
  logic [GAIN_W-1:0]   mix_eff;
  logic [GAIN_W-1:0]   fb_eff;
  sample_t             mix_l;
  sample_t             mix_rt;
  lane_ctrl_t          lane_ctrl;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid & in_tready;
  assign lane_start = (state_r == ST_LFO) & lfo_done;
  assign out_ld     = (state_r == ST_MERGE) & (!out_tvalid_r | out_tready);

  // gains above one count as one
  assign mix_eff = (mix_gain_r > GAIN_W'(ONE_Q15)) ? GAIN_W'(ONE_Q15) : mix_gain_r;
  assign fb_eff  = (fb_gain_r > GAIN_W'(ONE_Q15)) ? GAIN_W'(ONE_Q15) : fb_gain_r;

  assign lane_ctrl = '{
    start:    lane_start,
    clr_en:   (state_r == ST_CLEAR),
    clr_addr: clr_addr_r,
    wr_pos:   wp_r,
    mix_g:    mix_eff,
    fb_g:     fb_eff
  };

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_addr_r == '1) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_acc) state_nxt = ST_LFO;
      end
      ST_LFO: begin
        if (lfo_done) state_nxt = ST_LANE;
      end
      ST_LANE: begin
        if (lane_done_l) state_nxt = ST_MERGE;
      end
      ST_MERGE: begin
        if (out_ld) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control state and configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clr_addr_r   <= '0;
      wp_r         <= '0;
      out_tvalid_r <= 1'b0;
      mix_gain_r   <= GAIN_W'(16384);
      fb_gain_r    <= '0;
      phase_step_r <= '0;
      depth_r      <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) begin
        clr_addr_r <= clr_addr_r + 1'b1;
      end
      if (lane_done_l) begin
        wp_r <= wp_r + 1'b1;
      end
      if (out_ld) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_addr))
          REG_MIX:        mix_gain_r   <= cfg_wdata[GAIN_W-1:0];
          REG_FEEDBACK:   fb_gain_r    <= cfg_wdata[GAIN_W-1:0];
          REG_PHASE_STEP: phase_step_r <= cfg_wdata[PSTEP_W-1:0];
          REG_DEPTH:      depth_r      <= cfg_wdata[DEPTH_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // input beat capture and output merge register
  always_ff @(posedge clk) begin
    if (in_acc) begin
      left_in_r  <= in_tdata[15:0];
      right_in_r <= in_tdata[31:16];
      last_r     <= in_tlast;
    end
    if (out_ld) begin
      out_tdata_r <= {mix_rt, mix_l};
      out_tlast_r <= last_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;

  // shared modulation source
  chorus_lfo u_lfo (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (in_acc),
    .phase_step (phase_step_r),
    .depth      (depth_r),
    .done       (lfo_done),
    .ofs_int    (ofs_int),
    .ofs_frac   (ofs_frac)
  );

  // channel lanes
  chorus_lane u_lane_left (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (lane_ctrl),
    .sample_in (left_in_r),
    .ofs_int   (ofs_int),
    .ofs_frac  (ofs_frac),
    .done      (lane_done_l),
    .mix_out   (mix_l)
  );

  chorus_lane u_lane_right (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (lane_ctrl),
    .sample_in (right_in_r),
    .ofs_int   (ofs_int),
    .ofs_frac  (ofs_frac),
    .done      (lane_done_r),
    .mix_out   (mix_rt)
  );

  // checks
  a_lfo_in_state: assert property (@(posedge clk) disable iff (!rst_n)
    lfo_done |-> state_r == ST_LFO)
    else $error("lfo finished outside its wait state");

  a_lanes_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    lane_done_l == lane_done_r)
    else $error("channel lanes out of step");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_tready)
    else $error("second beat taken while one is in flight");

  a_no_out_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CLEAR |-> !out_tvalid_r)
    else $error("result beat during clearing pass");

endmodule

[rtl/core/chorus_lfo.sv]
// ----------------------------------------------------------------------------
// chorus_lfo
// Phase accumulator, polynomial sine and depth scaling; yields the delay
// offset split into a whole sample part and a q.15 fraction.
// ----------------------------------------------------------------------------
module chorus_lfo
  import chorus_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [PSTEP_W-1:0]  phase_step,
  input  logic [DEPTH_W-1:0]  depth,
  output logic                done,
  output logic [STORE_AW-1:0] ofs_int,
  output logic [FRAC_W-1:0]   ofs_frac
);

  logic [PHASE_W-1:0]           phase_r;
  logic [5:0]                   tok_r;
  logic [TBL_LOG2-1:0]          k;
  logic [1:0]                   quad;
  logic [FRAC_W-1:0]            u_pre;
  logic [15:0]                  u_mir;
  logic [31:0]                  sq;
  logic [31:0]                  lin;
  logic [31:0]                  p3;
  logic [31:0]                  p5;
  logic [31:0]                  poly;
  logic signed [SINE_W-1:0]     s_mag;
  logic signed [OFS_W-1:0]      prod;
  logic [1:0]                   q_r;
  logic [15:0]                  u_r;
  logic [15:0]                  u2_r;
  logic [15:0]                  u3_r;
  logic [15:0]                  u5_r;
  logic [31:0]                  lin_r;
  logic [31:0]                  c3_r;
  logic signed [SINE_W-1:0]     s_r;
  logic signed [OFS_W-1:0]      a_r;

  // phase advance and stage tokens
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
      tok_r   <= '0;
    end else begin
      tok_r <= {tok_r[4:0], start};
      if (start) begin
        phase_r <= phase_r + PHASE_W'(phase_step);
      end
    end
  end

  // table index, quadrant and mirrored position inside the quadrant
  assign k     = phase_r[PHASE_W-1 -: TBL_LOG2];
  assign quad  = k[TBL_LOG2-1 -: 2];
  assign u_pre = {k[TBL_LOG2-3:0], {(17 - TBL_LOG2){1'b0}}};
  assign u_mir = quad[0] ? (16'(ONE_Q15) - {1'b0, u_pre}) : {1'b0, u_pre};

  // polynomial terms, computed across the pipeline registers below
  assign sq    = {16'b0, u_mir} * {16'b0, u_mir};
  assign lin   = {16'b0, u_mir} * 32'd51472;
  assign p3    = {16'b0, u2_r} * {16'b0, u_r};
  assign p5    = {16'b0, u3_r} * {16'b0, u2_r};
  assign poly  = lin_r + {16'b0, u5_r} * 32'd2320 - c3_r;
  assign s_mag = signed'({1'b0, poly[30:15]});
  assign prod  = OFS_W'(s_r) * OFS_W'(signed'({1'b0, depth}));

  always_ff @(posedge clk) begin
    q_r   <= quad;
    u_r   <= u_mir;
    u2_r  <= sq[30:15];
    lin_r <= lin;
    u3_r  <= p3[30:15];
    u5_r  <= p5[30:15];
    c3_r  <= {16'b0, u3_r} * 32'd21024;
    s_r   <= q_r[1] ? -s_mag : s_mag;
    a_r   <= prod;
  end

  // floor split: arithmetic shift gives the whole part, low bits the fraction
  assign done     = tok_r[5];
  assign ofs_int  = a_r[FRAC_W +: STORE_AW];
  assign ofs_frac = a_r[FRAC_W-1:0];

endmodule

[rtl/core/chorus_lane.sv]
// ----------------------------------------------------------------------------
// chorus_lane
// One channel: delay store, interpolated tap read, dry/wet mix and the
// feedback write back into the store.
// ----------------------------------------------------------------------------
module chorus_lane
  import chorus_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  lane_ctrl_t          ctrl,
  input  sample_t             sample_in,
  input  logic [STORE_AW-1:0] ofs_int,
  input  logic [FRAC_W-1:0]   ofs_frac,
  output logic                done,
  output sample_t             mix_out
);

  // q1.15 weighted blend with floor and saturation
  function automatic sample_t blend(sample_t a, sample_t b, logic [GAIN_W-1:0] g);
    logic [GAIN_W-1:0]       gi;
    logic signed [ACC_W-1:0] acc;
    logic signed [FL_W-1:0]  fl;
    sample_t                 res;
    gi  = GAIN_W'(ONE_Q15) - g;
    acc = ACC_W'(a) * ACC_W'(signed'({1'b0, gi})) + ACC_W'(b) * ACC_W'(signed'({1'b0, g}));
    fl  = FL_W'(acc >>> FRAC_W);
    if ((&fl[FL_W-1:SAMPLE_W-1]) || !(|fl[FL_W-1:SAMPLE_W-1])) begin
      res = fl[SAMPLE_W-1:0];
    end else if (fl[FL_W-1]) begin
      res = {1'b1, {(SAMPLE_W - 1){1'b0}}};
    end else begin
      res = {1'b0, {(SAMPLE_W - 1){1'b1}}};
    end
    return res;
  endfunction

  sample_t             mem [STORE_DEPTH];
  logic [2:0]          tok_r;
  logic [STORE_AW-1:0] rd0;
  logic [STORE_AW-1:0] rd1;
  logic                we;
  logic [STORE_AW-1:0] wa;
  sample_t             wd;
  sample_t             t0_r;
  sample_t             t1_r;
  sample_t             wet_r;
  sample_t             mix_r;

  // tap addresses around the point DELAY_SAMPLES behind the write position
  assign rd0 = ctrl.wr_pos - STORE_AW'(DELAY_SAMPLES) + ofs_int;
  assign rd1 = rd0 + 1'b1;

  // write port: clearing pass or the feedback sample
  assign we = ctrl.clr_en | tok_r[2];
  assign wa = ctrl.clr_en ? ctrl.clr_addr : ctrl.wr_pos;
  assign wd = ctrl.clr_en ? sample_t'(0) : blend(sample_in, mix_r, ctrl.fb_g);

  // delay store, two registered reads
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    t0_r <= mem[rd0];
    t1_r <= mem[rd1];
  end

  // step tokens
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
    end else begin
      tok_r <= {tok_r[1:0], ctrl.start};
    end
  end

  // interpolation and mix
  always_ff @(posedge clk) begin
    wet_r <= blend(t0_r, t1_r, {1'b0, ofs_frac});
    if (tok_r[1]) begin
      mix_r <= blend(sample_in, wet_r, ctrl.mix_g);
    end
  end

  assign done    = tok_r[2];
  assign mix_out = mix_r;

endmodule

[test/tb_stereo_chorus_modulated_delay.sv]
// ----------------------------------------------------------------------------
// tb_stereo_chorus_modulated_delay
// Self-checking bench for the stereo chorus. Stereo beats are streamed in
// bursts through a queue-fed driver while the result side stalls on a rotating
// ready pattern. Every accepted input beat runs through a bit-exact model of
// the lfo, the interpolated delay read, the mix and the feedback write, and
// the monitor checks each result beat field by field against the oldest
// prediction. Register settings change between phases once the block is idle.
// ----------------------------------------------------------------------------
module tb_stereo_chorus_modulated_delay;
  timeunit 1ns;
  timeprecision 1ps;
  import chorus_pkg::*;

  localparam longint LFO_TABLE   = 2 ** TBL_LOG2;
  localparam longint SAMPLE_MAX  = 2 ** (SAMPLE_W - 1) - 1;
  localparam longint SAMPLE_MIN  = -(2 ** (SAMPLE_W - 1));
  localparam int     IDLE_SETTLE = 16;
  localparam int     STALL_LIMIT = 8000;

  typedef struct packed {
    sample_t left;
    sample_t right;
    logic    last;
  } stereo_pair_t;

  // dut ports
  logic                clk        = 1'b0;
  logic                rst_n      = 1'b0;
  logic                in_tvalid  = 1'b0;
  logic                in_tready;
  logic [31:0]         in_tdata   = '0;   // [15:0] left_in, [31:16] right_in
  logic                in_tlast   = 1'b0; // block_last
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [31:0]         out_tdata;         // [15:0] left_out, [31:16] right_out
  logic                out_tlast;         // block_last_out
  logic                cfg_we     = 1'b0;
  logic [CFG_AW-1:0]   cfg_addr   = '0;
  logic [CFG_W-1:0]    cfg_wdata  = '0;

  // stimulus and checking state
  stereo_pair_t pending_pairs[$];
  stereo_pair_t chorus_expected[$];
  int           error_count   = 0;
  int           idle_cycles   = 0;
  int           burst_left    = 1;
  int           gap_left      = 0;
  bit           sender_bursty = 1'b0;
  logic [15:0]  rx_mask       = 16'hFFFF;
  logic [3:0]   rx_step       = '0;
  logic         in_beat_taken = 1'b0;

  // model of the chorus state and registers
  sample_t             delay_line [2][STORE_DEPTH];
  logic [STORE_AW-1:0] wr_ptr;
  logic [PHASE_W-1:0]  lfo_acc;
  logic [GAIN_W-1:0]   mix_gain_q;
  logic [GAIN_W-1:0]   fb_gain_q;
  logic [PSTEP_W-1:0]  phase_inc;
  logic [DEPTH_W-1:0]  depth_q;

  wire in_fire  = in_tvalid && in_tready;
  wire out_fire = out_tvalid && out_tready;

  stereo_chorus_modulated_delay dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // q1.15 sine from the lfo phase: polynomial per quadrant, mirrored and negated
  function automatic longint lfo_sine(input logic [PHASE_W-1:0] ph);
    longint k, q, r, u, u2, u3, u5, s;
    k = ({32'd0, ph} * LFO_TABLE) >> 32;
    q = (k * 4) / LFO_TABLE;
    r = k * 4 - q * LFO_TABLE;
    u = (r <<< FRAC_W) / LFO_TABLE;
    q = q & 3;
    if (q[0]) u = ONE_Q15 - u;
    u2 = (u * u) >>> FRAC_W;
    u3 = (u2 * u) >>> FRAC_W;
    u5 = (u3 * u2) >>> FRAC_W;
    s = (51472 * u + 2320 * u5 - 21024 * u3) >>> FRAC_W;
    return (q >= 2) ? -s : s;
  endfunction

  function automatic sample_t clip(input longint v);
    if (v > SAMPLE_MAX) return sample_t'(SAMPLE_MAX);
    if (v < SAMPLE_MIN) return sample_t'(SAMPLE_MIN);
    return sample_t'(v);
  endfunction

  // one channel: interpolated tap pair, dry/wet mix, feedback write
  function automatic sample_t delay_channel(input int ch, input longint dry, input longint ip,
                                            input longint fr, input longint m, input longint f);
    longint              base, t0, t1, wet, mix;
    logic [STORE_AW-1:0] a0, a1;
    base = longint'(wr_ptr) - DELAY_SAMPLES + ip;
    a0   = base[STORE_AW-1:0];
    a1   = a0 + 1'b1;
    t0   = delay_line[ch][a0];
    t1   = delay_line[ch][a1];
    wet  = (t0 * (ONE_Q15 - fr) + t1 * fr) >>> FRAC_W;
    mix  = clip((dry * (ONE_Q15 - m) + wet * m) >>> FRAC_W);
    delay_line[ch][wr_ptr] = clip((dry * (ONE_Q15 - f) + mix * f) >>> FRAC_W);
    return sample_t'(mix);
  endfunction

  // advance the chorus model by one stereo beat
  function automatic stereo_pair_t chorus_step(input stereo_pair_t dry);
    longint       m, f, a, ip, fr;
    stereo_pair_t res;
    m       = (mix_gain_q > ONE_Q15) ? ONE_Q15 : longint'(mix_gain_q);
    f       = (fb_gain_q > ONE_Q15) ? ONE_Q15 : longint'(fb_gain_q);
    lfo_acc = lfo_acc + phase_inc;
    a       = lfo_sine(lfo_acc) * longint'(depth_q);
    ip      = a >>> FRAC_W;
    fr      = a - ip * ONE_Q15;
    res.left  = delay_channel(0, longint'(dry.left), ip, fr, m, f);
    res.right = delay_channel(1, longint'(dry.right), ip, fr, m, f);
    res.last  = dry.last;
    wr_ptr    = wr_ptr + 1'b1;
    return res;
  endfunction

  // input side: predict on every accepted beat
  always @(posedge clk) begin
    in_beat_taken <= rst_n && in_fire;
    if (rst_n && in_fire)
      chorus_expected.push_back(chorus_step('{left: sample_t'(in_tdata[15:0]),
                                              right: sample_t'(in_tdata[31:16]),
                                              last: in_tlast}));
  end

  // driver: bursts of beats, with random gaps between bursts in bursty phases
  always @(negedge clk) begin : drive_input
    stereo_pair_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_beat_taken) begin
      if (gap_left > 0) begin
        gap_left  <= gap_left - 1;
        in_tvalid <= 1'b0;
      end else if (pending_pairs.size() == 0) begin
        in_tvalid <= 1'b0;
      end else begin
        nxt = pending_pairs.pop_front();
        in_tdata  <= {nxt.right, nxt.left};
        in_tlast  <= nxt.last;
        in_tvalid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 12);
          gap_left   <= sender_bursty ? $urandom_range(0, 20) : 0;
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // result side ready follows a rotating pattern from the 16-bit rx_mask
  always @(negedge clk) begin
    rx_step    <= rx_step + 1'b1;
    out_tready <= rx_mask[rx_step];
  end

  // monitor: compare each result beat with the oldest prediction
  always @(posedge clk) begin : check_output
    stereo_pair_t got, want;
    if (rst_n && out_fire) begin
      got.left  = sample_t'(out_tdata[15:0]);
      got.right = sample_t'(out_tdata[31:16]);
      got.last  = out_tlast;
      if (chorus_expected.size() == 0) begin
        $display("%0t: result beat with nothing expected: left %0d right %0d last %0b",
                 $time, got.left, got.right, got.last);
        error_count++;
      end else begin
        want = chorus_expected.pop_front();
        if (got.left !== want.left) begin
          $display("%0t: left_out mismatch: expected %0d actual %0d",
                   $time, want.left, got.left);
          error_count++;
        end
        if (got.right !== want.right) begin
          $display("%0t: right_out mismatch: expected %0d actual %0d",
                   $time, want.right, got.right);
          error_count++;
        end
        if (got.last !== want.last) begin
          $display("%0t: block_last_out mismatch: expected %0b actual %0b",
                   $time, want.last, got.last);
          error_count++;
        end
      end
    end
  end

  // watchdog on cycles without any beat moving
  always @(posedge clk) begin
    if (in_fire || out_fire) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no beat moved for %0d cycles", $time, idle_cycles);
      $display("FAIL stereo_chorus_modulated_delay");
      $finish;
    end
  end

  function automatic sample_t random_sample();
    case ($urandom_range(0, 5))
      0:       return sample_t'(SAMPLE_MIN);
      1:       return sample_t'(SAMPLE_MAX);
      2:       return sample_t'(int'($urandom_range(0, 64)) - 32);
      default: return sample_t'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] random_rx_mask();
    case ($urandom_range(0, 3))
      0:       return 16'hFFFF;
      1:       return 16'h0001;
      default: return 16'($urandom) | 16'h8000;
    endcase
  endfunction

  task automatic push_pair(input logic [15:0] l, input logic [15:0] r, input logic last);
    pending_pairs.push_back('{left: sample_t'(l), right: sample_t'(r), last: last});
  endtask

  // block until every queued beat is taken and every result has come back
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_pairs.size() != 0 || in_tvalid || chorus_expected.size() != 0);
    repeat (IDLE_SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t sel, input logic [CFG_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_addr  <= sel;
    cfg_wdata <= value;
    @(negedge clk);
    case (sel)
      REG_MIX:        mix_gain_q = value[GAIN_W-1:0];
      REG_FEEDBACK:   fb_gain_q  = value[GAIN_W-1:0];
      REG_PHASE_STEP: phase_inc  = value[PSTEP_W-1:0];
      REG_DEPTH:      depth_q    = value[DEPTH_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_chorus(input logic [CFG_W-1:0] mix, input logic [CFG_W-1:0] fb,
                            input logic [CFG_W-1:0] pstep, input logic [CFG_W-1:0] depth);
    write_reg(REG_MIX, mix);
    write_reg(REG_FEEDBACK, fb);
    write_reg(REG_PHASE_STEP, pstep);
    write_reg(REG_DEPTH, depth);
    cfg_we <= 1'b0;
  endtask

  // one phase of random beats under the current settings
  task automatic run_random(input int count, input bit bursty, input logic [15:0] mask);
    sender_bursty = bursty;
    rx_mask       = mask;
    repeat (count)
      pending_pairs.push_back('{left: random_sample(), right: random_sample(),
                                last: ($urandom_range(0, 7) == 0)});
    wait_idle();
  endtask

  initial begin
    // model reset state
    for (int i = 0; i < STORE_DEPTH; i++) begin
      delay_line[0][i] = '0;
      delay_line[1][i] = '0;
    end
    wr_ptr     = '0;
    lfo_acc    = '0;
    mix_gain_q = 16384;
    fb_gain_q  = 0;
    phase_inc  = 0;
    depth_q    = 0;

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // directed: sample extremes and block marks at the reset settings
    push_pair(16'h0000, 16'h0000, 1'b0);
    push_pair(16'h7FFF, 16'h8000, 1'b1);
    push_pair(16'h8000, 16'h7FFF, 1'b0);
    push_pair(16'hFFFF, 16'h0001, 1'b0);
    push_pair(16'h0001, 16'hFFFF, 1'b1);
    push_pair(16'h7FFF, 16'h7FFF, 1'b0);
    push_pair(16'h8000, 16'h8000, 1'b0);
    push_pair(16'h5555, 16'hAAAA, 1'b1);
    push_pair(16'hAAAA, 16'h5555, 1'b0);
    push_pair(16'hFFFF, 16'hFFFF, 1'b1);
    wait_idle();

    // fully dry, lfo stopped
    set_chorus(0, 0, 0, 0);
    run_random(100, 1'b1, random_rx_mask());
    // fully wet, full feedback, fastest step, deepest swing
    set_chorus(32768, 32768, 25'h1FFFFFF, 511);
    run_random(150, 1'b1, 16'h0001);
    // gains above one clamp to one, phase step of 1/256 turn
    set_chorus(65535, 65535, 25'h1000000, 511);
    run_random(100, 1'b0, 16'hFFFF);
    // slow lfo with a moderate blend, no idling on either side
    set_chorus(16384, 8192, 1000, 100);
    run_random(200, 1'b0, 16'hFFFF);
    // random settings, now and then a gain above one
    repeat (5) begin
      set_chorus(CFG_W'(($urandom_range(0, 5) == 0) ? $urandom_range(32769, 65535)
                                                    : $urandom_range(0, 32768)),
                 CFG_W'(($urandom_range(0, 5) == 0) ? $urandom_range(32769, 65535)
                                                    : $urandom_range(0, 32768)),
                 CFG_W'(($urandom_range(0, 1) == 0) ? $urandom_range(0, 25'h1FFFFFF)
                                                    : $urandom_range(0, 65535)),
                 CFG_W'($urandom_range(0, 511)));
      run_random(130, 1'($urandom_range(0, 1)), random_rx_mask());
    end

    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("PASS stereo_chorus_modulated_delay");
    end else begin
      $display("FAIL stereo_chorus_modulated_delay");
    end
    $finish;
  end

endmodule
